### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for the backlight soft-start block
// Widths, operation/status codes and controller-datapath handshake structs.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int LEVEL_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 16;
  localparam int NUM_W    = LEVEL_W + PERIOD_W;
  localparam int CNT_W    = $clog2(NUM_W);

  localparam int MAX_LEVEL  = 100;
  localparam int KICK_TICKS = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd999;
  localparam logic [LEVEL_W-1:0]  RANGE_RST  = 8'd100;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_OFF  = 2'd2,
    OP_ON   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_APPLIED   = 2'd0,
    STS_UNCHANGED = 2'd1,
    STS_BUSY      = 2'd2,
    STS_RAMP      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PIN_OFF = 2'd0,
    PIN_ON  = 2'd1,
    PIN_PWM = 2'd2
  } pin_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SOFT = 2'd1,
    PH_KICK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_RANGE  = 2'd1,
    CFG_INVERT = 2'd2,
    CFG_SOFT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;     // latch the decision for the incoming transaction
    logic mul;        // form level*period + range/2
    logic div_start;  // launch the divider
    logic cmp_load;   // load rounded quotient into the compare register
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic need_drive;
    logic div_done;
  } sts_t;

endpackage

### rtl/bls_in_if.sv
// ----------------------------------------------------------------------------
// bls_in_if: request channel
// Valid/ready channel carrying one operation and its requested level.
// ----------------------------------------------------------------------------
interface bls_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [bls_pkg::LEVEL_W-1:0] requested_level;

  modport source (output valid, op, requested_level, input ready);
  modport sink   (input valid, op, requested_level, output ready);
endinterface

### rtl/bls_out_if.sv
// ----------------------------------------------------------------------------
// bls_out_if: result channel
// Valid/ready channel carrying the compare value and pin state.
// ----------------------------------------------------------------------------
interface bls_out_if;
  logic                         valid;
  logic                         ready;
  logic [bls_pkg::PERIOD_W-1:0] duty_compare;
  logic [1:0]                   pin_mode;
  logic                         pin_level;
  logic [bls_pkg::LEVEL_W-1:0]  applied_level;
  logic                         ramping;
  logic [1:0]                   status;

  modport source (output valid, duty_compare, pin_mode, pin_level, applied_level,
                  ramping, status, input ready);
  modport sink   (input valid, duty_compare, pin_mode, pin_level, applied_level,
                  ramping, status, output ready);
endinterface

### rtl/bls_div.sv
// ----------------------------------------------------------------------------
// bls_div: restoring divider
// One quotient bit per cycle while busy; done_o rises after the last bit.
// ----------------------------------------------------------------------------
module bls_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bls_pkg::NUM_W-1:0]    num_i,
  input  logic [bls_pkg::LEVEL_W-1:0]  den_i,
  output logic                         done_o,
  output logic [bls_pkg::NUM_W-1:0]    quo_o
);
  import bls_pkg::*;

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]   quo_q;
  logic [LEVEL_W-1:0] rem_q;
  logic [LEVEL_W-1:0] den_q;
  logic [LEVEL_W:0]   rem_sh, rem_sub;
  logic               ge;

  // quotient bits shift in from the bottom as dividend bits leave the top
  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[LEVEL_W-1:0] : rem_sh[LEVEL_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/bls_dp.sv
// ----------------------------------------------------------------------------
// bls_dp: backlight datapath
// Config registers, level/ramp state, compare arithmetic and result register.
// ----------------------------------------------------------------------------
module bls_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bls_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]                    op_i,
  input  logic [bls_pkg::LEVEL_W-1:0]   req_level_i,
  input  bls_pkg::cmd_t                 cmd_i,
  output bls_pkg::sts_t                 sts_o,
  output logic [bls_pkg::PERIOD_W-1:0]  duty_compare_o,
  output logic [1:0]                    pin_mode_o,
  output logic                          pin_level_o,
  output logic [bls_pkg::LEVEL_W-1:0]   applied_level_o,
  output logic                          ramping_o,
  output logic [1:0]                    status_o
);
  import bls_pkg::*;

  localparam logic [LEVEL_W-1:0] MaxLvl  = LEVEL_W'(MAX_LEVEL);
  localparam logic [LEVEL_W-1:0] LastRst = LEVEL_W'(MAX_LEVEL + 1);

  // configuration
  logic [PERIOD_W-1:0] period_q;
  logic [LEVEL_W-1:0]  range_q;
  logic                invert_q, soft_q;

  // level state
  logic [LEVEL_W-1:0]  last_q, rlev_q, tgt_q;
  logic                powered_q;
  logic [1:0]          phase_q, kick_q;
  logic [PERIOD_W-1:0] hold_q;

  logic [LEVEL_W-1:0]  drv_q;
  logic [NUM_W-1:0]    prod_q;
  logic [1:0]          status_q;

  // decision for the incoming transaction
  logic [LEVEL_W-1:0]  last_d, rlev_d, tgt_d, drv_d, req_lvl, clamp_lvl, rl_inc;
  logic                powered_d, do_req, drive_d, hold_ld;
  logic [1:0]          phase_d, kick_d, status_d;

  logic [LEVEL_W-1:0]  rng_eff;
  logic [NUM_W-1:0]    prod_d, quo;
  logic [PERIOD_W-1:0] cmp_sat;
  logic                div_done;

  assign rng_eff   = (range_q == '0) ? LEVEL_W'(1) : range_q;
  assign clamp_lvl = (req_level_i > MaxLvl) ? MaxLvl : req_level_i;
  assign rl_inc    = rlev_q + LEVEL_W'(1);

  always_comb begin
    last_d    = last_q;
    rlev_d    = rlev_q;
    tgt_d     = tgt_q;
    powered_d = powered_q;
    phase_d   = phase_q;
    kick_d    = kick_q;
    drv_d     = drv_q;
    drive_d   = 1'b0;
    hold_ld   = 1'b0;
    do_req    = 1'b0;
    req_lvl   = '0;
    status_d  = STS_UNCHANGED;

    priority if (op_i == OP_TICK) begin
      if (phase_q == PH_SOFT) begin
        rlev_d  = rl_inc;
        drive_d = 1'b1;
        if (rl_inc >= tgt_q) begin
          drv_d    = tgt_q;
          last_d   = tgt_q;
          phase_d  = PH_IDLE;
          status_d = STS_APPLIED;
        end else begin
          drv_d    = rl_inc;
          status_d = STS_RAMP;
        end
      end else if (phase_q == PH_KICK) begin
        kick_d = (kick_q != '0) ? kick_q - 2'd1 : kick_q;
        if (kick_d == '0) begin
          drive_d  = 1'b1;
          drv_d    = tgt_q;
          last_d   = tgt_q;
          phase_d  = PH_IDLE;
          status_d = STS_APPLIED;
        end else begin
          status_d = STS_RAMP;
        end
      end
    end else if (phase_q != PH_IDLE) begin
      status_d = STS_BUSY;
    end else begin
      unique case (op_i)
        OP_SET: begin
          do_req  = 1'b1;
          req_lvl = powered_q ? clamp_lvl : '0;
        end
        OP_OFF: begin
          if (powered_q) begin
            powered_d = 1'b0;
            do_req    = 1'b1;
            req_lvl   = '0;
          end
        end
        OP_ON: begin
          if (!powered_q) begin
            powered_d = 1'b1;
            do_req    = 1'b1;
            req_lvl   = MaxLvl;
          end
        end
        default: ;
      endcase
    end

    if (do_req) begin
      priority if (req_lvl == last_q) begin
        status_d = STS_UNCHANGED;
      end else if (last_q == '0 && req_lvl != '0 && soft_q && req_lvl > LEVEL_W'(1)) begin
        phase_d  = PH_SOFT;
        rlev_d   = LEVEL_W'(1);
        tgt_d    = req_lvl;
        drive_d  = 1'b1;
        drv_d    = LEVEL_W'(1);
        status_d = STS_RAMP;
      end else if (last_q == '0 && req_lvl != '0 && !soft_q) begin
        // full-scale kick: compare goes straight to the period
        phase_d  = PH_KICK;
        rlev_d   = range_q;
        tgt_d    = req_lvl;
        kick_d   = 2'(KICK_TICKS);
        hold_ld  = 1'b1;
        status_d = STS_RAMP;
      end else begin
        drive_d  = 1'b1;
        drv_d    = req_lvl;
        last_d   = req_lvl;
        status_d = STS_APPLIED;
      end
    end
  end

  assign prod_d  = NUM_W'(drv_q) * NUM_W'(period_q) + NUM_W'(rng_eff >> 1);
  assign cmp_sat = (quo > NUM_W'(period_q)) ? period_q : quo[PERIOD_W-1:0];

  bls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (rng_eff),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign sts_o.need_drive = drive_d;
  assign sts_o.div_done   = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      range_q   <= RANGE_RST;
      invert_q  <= 1'b0;
      soft_q    <= 1'b0;
      last_q    <= LastRst;
      powered_q <= 1'b1;
      phase_q   <= PH_IDLE;
      rlev_q    <= '0;
      tgt_q     <= '0;
      kick_q    <= '0;
      hold_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_RANGE:  range_q  <= cfg_data_i[LEVEL_W-1:0];
          CFG_INVERT: invert_q <= cfg_data_i[0];
          CFG_SOFT:   soft_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        last_q    <= last_d;
        powered_q <= powered_d;
        phase_q   <= phase_d;
        rlev_q    <= rlev_d;
        tgt_q     <= tgt_d;
        kick_q    <= kick_d;
        if (hold_ld) begin
          hold_q <= period_q;
        end
      end else if (cmd_i.cmp_load) begin
        hold_q <= cmp_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      drv_q    <= drv_d;
      status_q <= status_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      duty_compare_o  <= hold_q;
      applied_level_o <= (phase_q != PH_IDLE) ? rlev_q : last_q;
      ramping_o       <= phase_q != PH_IDLE;
      status_o        <= status_q;
      priority if (hold_q == '0) begin
        pin_mode_o  <= PIN_OFF;
        pin_level_o <= invert_q;
      end else if (hold_q == period_q) begin
        pin_mode_o  <= PIN_ON;
        pin_level_o <= ~invert_q;
      end else begin
        pin_mode_o  <= PIN_PWM;
        pin_level_o <= 1'b0;
      end
    end
  end

endmodule

### rtl/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl: sequencing controller
// Accepts a transaction, runs multiply and divide when a new compare is
// needed, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bls_pkg::sts_t sts_i,
  output bls_pkg::cmd_t cmd_o
);
  import bls_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_drive ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.cmp_load = 1'b1;
          state_d        = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_drive_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && !sts_i.need_drive |=> state_q == ST_FIN)
    else $error("transaction without drive did not go to finish");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && !sts_i.div_done |=> state_q == ST_DIV)
    else $error("left divide state before quotient was ready");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise valid");

endmodule

### rtl/backlight_level_soft_start_core.sv
// ----------------------------------------------------------------------------
// backlight_level_soft_start_core: PWM backlight level controller
// Level requests, millisecond ticks and power events in; PWM compare out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries op (set level, tick, power off, power on) and a level.
//   out_o returns one result per transaction: compare value, pin mode,
//   forced pin level, applied level, ramp flag and status.
//   cfg_we_i/cfg_idx_i/cfg_data_i write period, range, invert and soft-start
//   mode; write them only while no transaction is in flight.
// Sequencing:
//   A transaction that loads a new compare value goes from accept through
//   a multiply step, a divider launch, the one-bit-per-cycle restoring
//   divider, its done cycle and the result load.
//   Others (unchanged, busy, kick start, mid-kick ticks) skip to the load.
//   One transaction is worked at a time; in_i.ready is high only when idle.
// Reset: configuration returns to period 999, range 100, no inversion, kick
//   mode; level state reads "never applied", powered, no ramp, compare 0.
// Stall: a finished result waits in the output register; the next transaction
//   is accepted meanwhile and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module backlight_level_soft_start_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [bls_pkg::CFG_W-1:0] cfg_data_i,
  bls_in_if.sink                    in_i,
  bls_out_if.source                 out_o
);
  import bls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bls_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (in_i.op),
    .req_level_i     (in_i.requested_level),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .duty_compare_o  (out_o.duty_compare),
    .pin_mode_o      (out_o.pin_mode),
    .pin_level_o     (out_o.pin_level),
    .applied_level_o (out_o.applied_level),
    .ramping_o       (out_o.ramping),
    .status_o        (out_o.status)
  );

endmodule
